FILE: design/hss_pkg.sv
// Shared constants, command codes and types for the Horspool substring search core.
package hss_pkg;

   localparam int PATTERN_MAX_DEF = 64;
   localparam int TEXT_MAX_DEF    = 4096;
   localparam int ALPHABET_SIZE   = 256;
   localparam int SYM_W           = $clog2(ALPHABET_SIZE);
   localparam int POS_W           = 12;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_PATTERN = 2'd1;
   localparam logic [1:0] CMD_TEXT    = 2'd2;
   localparam logic [1:0] CMD_SEARCH  = 2'd3;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [POS_W-1:0] pos;
   } hss_result_type;

endpackage

FILE: design/hss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hss_engine.sv
// Search sequencer: shift table build and Horspool scan over the pattern and text RAMs.
module hss_engine import hss_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = TEXT_MAX_DEF,
   localparam int PLEN_W     = $clog2(PATTERN_MAX + 1),
   localparam int TLEN_W     = $clog2(TEXT_MAX + 1),
   localparam int PA_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
   localparam int TA_W       = $clog2(TEXT_MAX)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PLEN_W-1:0] pat_len,
   input  logic [TLEN_W-1:0] txt_len,
   output logic [PA_W-1:0]   pat_rd_addr,
   input  logic [SYM_W-1:0]  pat_rd_data,
   output logic [TA_W-1:0]   txt_rd_addr,
   input  logic [SYM_W-1:0]  txt_rd_data,
   output logic              sh_we,
   output logic [SYM_W-1:0]  sh_wr_addr,
   output logic [PLEN_W-1:0] sh_wr_data,
   output logic [SYM_W-1:0]  sh_rd_addr,
   input  logic [PLEN_W-1:0] sh_rd_data,
   input  logic              res_take,
   output logic              busy,
   output hss_result_type    result
);

   localparam int SUM_W = ((TLEN_W > PLEN_W) ? TLEN_W : PLEN_W) + 2;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_FILL      = 3'd1;
   localparam logic [2:0] S_BUILD     = 3'd2;
   localparam logic [2:0] S_CMP_RD    = 3'd3;
   localparam logic [2:0] S_CMP_CHK   = 3'd4;
   localparam logic [2:0] S_SHIFT_ADV = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [SYM_W-1:0]  fill_ff, fill_in;
   logic [PLEN_W-1:0] k_ff, k_in;
   logic              pend_ff, pend_in;
   logic [PLEN_W-1:0] pend_k_ff, pend_k_in;
   logic [TLEN_W-1:0] i_ff, i_in;
   logic [PLEN_W-1:0] j_ff, j_in;
   logic [SYM_W-1:0]  last_ff, last_in;
   logic              found_ff, found_in;

   logic [PLEN_W-1:0]        j_dec;
   logic [SUM_W-1:0]         taddr_sum;
   logic [SUM_W-1:0]         adv_sum;
   logic [POS_W+TLEN_W-1:0]  pos_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      fill_ff   <= fill_in;
      k_ff      <= k_in;
      pend_k_ff <= pend_k_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      last_ff   <= last_in;
      found_ff  <= found_in;
   end

   assign j_dec     = j_ff - PLEN_W'(1);
   assign taddr_sum = SUM_W'(i_ff) + SUM_W'(j_ff) - SUM_W'(1);
   assign adv_sum   = SUM_W'(i_ff) + SUM_W'(sh_rd_data);

   assign pat_rd_addr = (state_ff == S_BUILD) ? k_ff[PA_W-1:0] : j_dec[PA_W-1:0];
   assign txt_rd_addr = taddr_sum[TA_W-1:0];
   assign sh_rd_addr  = (j_ff == pat_len) ? txt_rd_data : last_ff;

   always_comb begin
      if (state_ff == S_FILL) begin
         sh_we      = 1'b1;
         sh_wr_addr = fill_ff;
         sh_wr_data = pat_len;
      end else begin
         sh_we      = pend_ff;
         sh_wr_addr = pat_rd_data;
         sh_wr_data = pat_len - PLEN_W'(1) - pend_k_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      k_in      = k_ff;
      pend_in   = 1'b0;
      pend_k_in = pend_k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      last_in   = last_ff;
      found_in  = found_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = pat_len;
               fill_in  = '0;
               k_in     = '0;
               found_in = 1'b0;
               if (pat_len == '0) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else if (SUM_W'(pat_len) > SUM_W'(txt_len)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            fill_in = fill_ff + SYM_W'(1);
            if (fill_ff == SYM_W'(ALPHABET_SIZE - 1)) begin
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            if (SUM_W'(k_ff) + SUM_W'(1) < SUM_W'(pat_len)) begin
               pend_in   = 1'b1;
               pend_k_in = k_ff;
               k_in      = k_ff + PLEN_W'(1);
            end else begin
               state_in = S_CMP_RD;
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CMP_CHK: begin
            if (j_ff == pat_len) begin
               last_in = txt_rd_data;
            end
            if (pat_rd_data == txt_rd_data) begin
               if (j_ff == PLEN_W'(1)) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  j_in     = j_dec;
                  state_in = S_CMP_RD;
               end
            end else begin
               state_in = S_SHIFT_ADV;
            end
         end
         S_SHIFT_ADV: begin
            j_in = pat_len;
            if (adv_sum + SUM_W'(pat_len) <= SUM_W'(txt_len)) begin
               i_in     = adv_sum[TLEN_W-1:0];
               state_in = S_CMP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign pos_wide     = {{POS_W{1'b0}}, i_ff};
   assign busy         = (state_ff != S_IDLE);
   assign result.done  = (state_ff == S_DONE);
   assign result.found = found_ff;
   assign result.pos   = found_ff ? pos_wide[POS_W-1:0] : '0;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("search start while engine busy");

   a_j_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP_CHK) |-> (j_ff != '0 && j_ff <= pat_len))
      else $error("compare index out of pattern range");

   a_text_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP_RD) |-> (SUM_W'(i_ff) + SUM_W'(j_ff) <= SUM_W'(txt_len)))
      else $error("text read beyond stored length");

   a_no_table_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP_CHK || state_ff == S_SHIFT_ADV) |-> !sh_we)
      else $error("shift table written during scan");

endmodule

FILE: design/horspool_substring_search_core.sv
// Top level: command decode, store lengths, RAM instances and result register.
// Clear and append beats are accepted one beat per cycle while the engine is not busy.
// Search: an empty pattern or a pattern longer than the text goes straight to done, otherwise
// the sequencer presets all 256 shift table entries, loads the table from the pattern,
// then compares bytes and shifts, all bound by the single read port of each RAM.
// The result is registered from the sequencer's done state. Reset clears lengths,
// overflow flag, sequencer and result valid; RAM contents are not cleared.
module horspool_substring_search_core import hss_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_found,
   output logic [POS_W-1:0] rsp_match_position,
   output logic             rsp_overflowed
);

   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int TLEN_W = $clog2(TEXT_MAX + 1);
   localparam int PA_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int TA_W   = $clog2(TEXT_MAX);

   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [TLEN_W-1:0] tlen_ff, tlen_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic              busy;
   logic              start;
   logic              pat_we;
   logic              txt_we;
   logic              res_take;
   hss_result_type    result;

   logic [PA_W-1:0]   pat_rd_addr;
   logic [SYM_W-1:0]  pat_rd_data;
   logic [TA_W-1:0]   txt_rd_addr;
   logic [SYM_W-1:0]  txt_rd_data;
   logic              sh_we;
   logic [SYM_W-1:0]  sh_wr_addr;
   logic [PLEN_W-1:0] sh_wr_data;
   logic [SYM_W-1:0]  sh_rd_addr;
   logic [PLEN_W-1:0] sh_rd_data;

   assign accept    = req_valid && !busy;
   assign req_stall = busy;
   assign res_take  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      plen_in = plen_ff;
      tlen_in = tlen_ff;
      ovf_in  = ovf_ff;
      pat_we  = 1'b0;
      txt_we  = 1'b0;
      start   = 1'b0;
      if (accept) begin
         unique case (req_command)
            CMD_CLEAR: begin
               plen_in = '0;
               tlen_in = '0;
               ovf_in  = 1'b0;
            end
            CMD_PATTERN: begin
               if (plen_ff < PLEN_W'(PATTERN_MAX)) begin
                  pat_we  = 1'b1;
                  plen_in = plen_ff + PLEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_TEXT: begin
               if (tlen_ff < TLEN_W'(TEXT_MAX)) begin
                  txt_we  = 1'b1;
                  tlen_in = tlen_ff + TLEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_SEARCH: begin
               start = 1'b1;
            end
            default: begin
               start = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (res_take) begin
         rsp_valid_in = result.done;
         rsp_found_in = result.found;
         rsp_pos_in   = result.pos;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         tlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   hss_ram #(
      .WIDTH (SYM_W),
      .DEPTH (PATTERN_MAX)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (plen_ff[PA_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

   hss_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TEXT_MAX)
   ) u_txt_ram (
      .clock   (clock),
      .wr_en   (txt_we),
      .wr_addr (tlen_ff[TA_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (txt_rd_addr),
      .rd_data (txt_rd_data)
   );

   hss_ram #(
      .WIDTH (PLEN_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_shift_ram (
      .clock   (clock),
      .wr_en   (sh_we),
      .wr_addr (sh_wr_addr),
      .wr_data (sh_wr_data),
      .rd_addr (sh_rd_addr),
      .rd_data (sh_rd_data)
   );

   hss_engine #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .pat_len     (plen_ff),
      .txt_len     (tlen_ff),
      .pat_rd_addr (pat_rd_addr),
      .pat_rd_data (pat_rd_data),
      .txt_rd_addr (txt_rd_addr),
      .txt_rd_data (txt_rd_data),
      .sh_we       (sh_we),
      .sh_wr_addr  (sh_wr_addr),
      .sh_wr_data  (sh_wr_data),
      .sh_rd_addr  (sh_rd_addr),
      .sh_rd_data  (sh_rd_data),
      .res_take    (res_take),
      .busy        (busy),
      .result      (result)
   );

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !(accept && req_command == CMD_CLEAR)) |=> ovf_ff)
      else $error("overflow flag dropped without a clear");

   a_len_stable_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> ($stable(plen_ff) && $stable(tlen_ff)))
      else $error("store length changed during search");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_found)
         && $stable(rsp_match_position) && $stable(rsp_overflowed)))
      else $error("result beat changed while stalled");

endmodule
